FILE: hdl/gkg_pkg.sv
// Shared types and constants of the Gaussian kernel generator.
`timescale 1ns / 1ps
package gkg_pkg;

    // Serial divider widths: numerator and quotient, divisor.
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 25;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // Exponent cutoff 12.0 in Q.16, at or above which the weight is zero.
    localparam logic [DIV_NW-1:0] EXP_CUTOFF = DIV_NW'(12) << 16;
    // Repeated squarings that undo the range reduction by 1024.
    localparam int SQUARINGS = 10;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

endpackage

FILE: hdl/gaussian_kernel_generator_top.sv
// Top level of the normalized Gaussian kernel generator.
`timescale 1ns / 1ps
// A request (sigma Q4.8, kernel size, 1D/2D mode) produces one normalized
// coefficient per tap in row-major order, tlast on the final tap. Each tap's
// raw weight exp(-d^2/(2 sigma^2)) is formed with one shared serial divider
// (the exponent d^2/(2 sigma^2)), one 32x32 multiplier (three series products,
// ten squarings) and reciprocal multiplies for the /6 and /24 series terms.
// Raw weights go to a RAM and are summed. The output pass reads each weight
// back and divides it by the sum. The divider is busy for a whole divide and
// each tap waits for its divide before the next is begun; the weight pass
// skips the multiplier when the exponent is past the cutoff, and the output
// pass also waits while the sink holds tready low. A request is accepted
// only when the previous one has handed its last tap to the output
// register. A zero sigma or size gives a single transfer with the error
// flag (tuser) set.
module gaussian_kernel_generator_top #(
    parameter int MAX_SIZE        = 8,
    parameter int COEFF_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sigma, [15:12] kernel_size
    input  logic        s_axis_tuser,   // [0] two_dimensional
    // Coefficient channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // coefficient, row (3), col (3), zero fill to whole bytes
    output logic [((COEFF_FRAC_BITS + 7 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] error
);

    localparam int TAPS   = MAX_SIZE * MAX_SIZE;
    localparam int AW     = TAPS > 1 ? $clog2(TAPS) : 1;
    localparam int IXW    = MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1;
    localparam int SW     = $clog2(MAX_SIZE + 1);
    localparam int SUM_W  = 17 + AW;
    localparam int COEF_W = COEFF_FRAC_BITS + 1;
    localparam int ODW    = ((COEF_W + 6 + 7) / 8) * 8;
    localparam int D2W    = 2 * IXW + 3;
    // floor(n / 3) = (n * RECIP3) >> 33 for any 32-bit n
    localparam logic [63:0] RECIP3 = 64'h0000_0000_AAAA_AAAB;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_XDIV, ST_XWAIT, ST_MUL, ST_MRND, ST_MDONE,
        ST_D6, ST_D24, ST_WRITE, ST_RD, ST_RDWAIT, ST_NWAIT
    } t_state;

    t_state r_state;

    // request
    logic [23:0]      r_s2;
    logic [SW-1:0]    r_size;
    logic             r_two_d;
    logic [IXW-1:0]   r_row, r_col;
    logic [AW-1:0]    r_addr;
    logic [SUM_W-1:0] r_sum;

    // exponential datapath
    logic [31:0] r_t, r_p2, r_p3, r_p4, r_d6, r_d24, r_ma, r_mb, r_mq;
    logic [63:0] r_prod;
    logic [3:0]  r_step;
    logic [15:0] r_w;

    // output register
    logic              r_ovalid, r_olast, r_oerr;
    logic [COEF_W-1:0] r_ocoef;
    logic [2:0]        r_orow, r_ocol;

    gkg_pkg::t_div_req r_div;
    gkg_pkg::t_div_rsp div_rsp;

    logic          r_we;
    logic [15:0]   ram_rdata;

    // tap geometry
    logic [IXW:0]     centre, dcol, drow;
    logic [D2W-1:0]   d2;
    logic [SW-1:0]    rows;
    logic             col_end, tap_last, out_free, div_done;
    logic [63:0]      rnd_sum;
    logic [63:0]      d6_prod, d24_prod;
    logic [32:0]      e_sum;
    logic [32:0]      w_sum;
    logic [SW-1:0]    in_size;
    logic [3:0]       in_ks;

    always_comb begin
        centre  = (IXW+1)'(r_size >> 1);
        dcol    = ({1'b0, r_col} >= centre) ? (IXW+1)'({1'b0, r_col} - centre)
                                            : (IXW+1)'(centre - {1'b0, r_col});
        drow    = !r_two_d ? '0
                : ({1'b0, r_row} >= centre) ? (IXW+1)'({1'b0, r_row} - centre)
                                            : (IXW+1)'(centre - {1'b0, r_row});
        d2      = D2W'(dcol) * D2W'(dcol) + D2W'(drow) * D2W'(drow);
        rows    = r_two_d ? r_size : SW'(1);
        col_end = (SW'(r_col) + SW'(1)) == r_size;
        tap_last = col_end && ((SW'(r_row) + SW'(1)) == rows);
        out_free = !r_ovalid || m_axis_tready;
        div_done = !div_rsp.busy && !r_div.start;
        rnd_sum  = r_prod + 64'h4000_0000;
        // p3/6 = (p3/2)/3 and p4/24 = (p4/8)/3, both floored
        d6_prod  = {32'b0, r_p3 >> 1} * RECIP3;
        d24_prod = {32'b0, r_p4 >> 3} * RECIP3;
        e_sum    = 33'h0_8000_0000 - 33'(r_t) + 33'(r_p2 >> 1) - 33'(r_d6)
                 + 33'(r_d24);
        w_sum    = 33'(r_mq) + 33'h4000;
        in_ks    = s_axis_tdata[15:12];
        in_size  = (32'(in_ks) > 32'(MAX_SIZE)) ? SW'(MAX_SIZE) : SW'(in_ks);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
        r_mq   <= rnd_sum[62:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ovalid    <= 1'b0;
            r_div.start <= 1'b0;
            r_we        <= 1'b0;
            r_sum       <= '0;
        end else begin
            r_div.start <= 1'b0;
            r_we        <= 1'b0;
            if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_s2    <= 24'(s_axis_tdata[11:0]) * 24'(s_axis_tdata[11:0]);
                        r_size  <= in_size;
                        r_two_d <= s_axis_tuser;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_addr  <= '0;
                        if (s_axis_tdata[11:0] == '0 || in_ks == '0) begin
                            r_state <= ST_ERR;
                        end else begin
                            r_sum   <= '0;
                            r_state <= ST_XDIV;
                        end
                    end
                end
                ST_ERR: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ocoef  <= '0;
                        r_orow   <= '0;
                        r_ocol   <= '0;
                        r_olast  <= 1'b1;
                        r_oerr   <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_XDIV: begin
                    r_div.start <= 1'b1;
                    r_div.num   <= (gkg_pkg::DIV_NW'(d2) << 31)
                                 + gkg_pkg::DIV_NW'(r_s2 >> 1);
                    r_div.den   <= gkg_pkg::DIV_DW'(r_s2);
                    r_state     <= ST_XWAIT;
                end
                ST_XWAIT: begin
                    if (div_done) begin
                        if (div_rsp.quot >= gkg_pkg::EXP_CUTOFF) begin
                            r_w     <= '0;
                            r_state <= ST_WRITE;
                        end else begin
                            r_t     <= {div_rsp.quot[26:0], 5'b0};
                            r_ma    <= {div_rsp.quot[26:0], 5'b0};
                            r_mb    <= {div_rsp.quot[26:0], 5'b0};
                            r_step  <= '0;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL:  r_state <= ST_MRND;
                ST_MRND: r_state <= ST_MDONE;
                ST_MDONE: begin
                    case (r_step)
                        4'd0: begin
                            r_p2    <= r_mq;
                            r_ma    <= r_mq;
                            r_mb    <= r_t;
                            r_step  <= 4'd1;
                            r_state <= ST_MUL;
                        end
                        4'd1: begin
                            r_p3    <= r_mq;
                            r_ma    <= r_mq;
                            r_step  <= 4'd2;
                            r_state <= ST_MUL;
                        end
                        4'd2: begin
                            r_p4    <= r_mq;
                            r_state <= ST_D6;
                        end
                        4'(2 + gkg_pkg::SQUARINGS): begin
                            r_w     <= (w_sum[32:15] > 18'hFFFF) ? 16'hFFFF
                                                                 : w_sum[30:15];
                            r_state <= ST_WRITE;
                        end
                        default: begin
                            r_ma    <= r_mq;
                            r_mb    <= r_mq;
                            r_step  <= r_step + 1'b1;
                            r_state <= ST_MUL;
                        end
                    endcase
                end
                ST_D6: begin
                    r_d6    <= {1'b0, d6_prod[63:33]};
                    r_d24   <= {1'b0, d24_prod[63:33]};
                    r_state <= ST_D24;
                end
                ST_D24: begin
                    r_ma    <= e_sum[31:0];
                    r_mb    <= e_sum[31:0];
                    r_step  <= 4'd3;
                    r_state <= ST_MUL;
                end
                ST_WRITE: begin
                    r_we  <= 1'b1;
                    r_sum <= r_sum + SUM_W'(r_w);
                    if (tap_last) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= ST_RD;
                    end else begin
                        r_state <= ST_XDIV;
                        if (col_end) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                ST_RD: begin
                    // read address is r_addr; data lands next cycle.
                    // Hold while the last weight is still being written.
                    if (!r_we) begin
                        r_state <= ST_RDWAIT;
                    end
                end
                ST_RDWAIT: begin
                    r_div.start <= 1'b1;
                    r_div.num   <= (gkg_pkg::DIV_NW'(ram_rdata) << COEFF_FRAC_BITS)
                                 + gkg_pkg::DIV_NW'(r_sum >> 1);
                    r_div.den   <= gkg_pkg::DIV_DW'(r_sum);
                    r_state     <= ST_NWAIT;
                end
                ST_NWAIT: begin
                    if (div_done && out_free) begin
                        r_ovalid <= 1'b1;
                        r_ocoef  <= (r_sum == '0) ? '0 : div_rsp.quot[COEF_W-1:0];
                        r_orow   <= 3'(r_row);
                        r_ocol   <= 3'(r_col);
                        r_olast  <= tap_last;
                        r_oerr   <= 1'b0;
                        r_addr   <= r_addr + 1'b1;
                        if (tap_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_RD;
                            if (col_end) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // write address has its own counter, cleared in idle and advanced after each write
    logic [AW-1:0] r_waddr;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_waddr <= '0;
        end else if (r_we) begin
            r_waddr <= r_waddr + 1'b1;
        end
    end

    gkg_ram #(
        .WIDTH(16),
        .DEPTH(TAPS)
    ) u_weights (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(r_waddr),
        .i_wdata(r_w),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    gkg_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_div),
        .o_rsp  (div_rsp)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = ODW'({r_ocol, r_orow, r_ocoef});
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oerr;

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("error transfer without tlast");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error transfer with nonzero payload");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_no_write_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_we |-> r_state != ST_NWAIT && r_state != ST_RDWAIT)
        else $error("weight write during output pass");

endmodule

FILE: hdl/gkg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module gkg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/gkg_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gkg_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gkg_pkg::t_div_req i_req,
    output gkg_pkg::t_div_rsp o_rsp
);

    logic [gkg_pkg::DIV_NW-1:0] r_num;
    logic [gkg_pkg::DIV_DW-1:0] r_den;
    logic [gkg_pkg::DIV_DW:0]   r_rem;
    logic [gkg_pkg::DIV_CW-1:0] r_cnt;
    logic                       r_busy;

    logic [gkg_pkg::DIV_DW+1:0] n_trial;
    logic                       n_fit;

    always_comb begin
        n_trial = {r_rem, r_num[gkg_pkg::DIV_NW-1]};
        n_fit   = n_trial >= {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= gkg_pkg::DIV_CW'(gkg_pkg::DIV_NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == gkg_pkg::DIV_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_fit ? (gkg_pkg::DIV_DW+1)'(n_trial - {2'b00, r_den})
                           : n_trial[gkg_pkg::DIV_DW:0];
            r_num <= {r_num[gkg_pkg::DIV_NW-2:0], n_fit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_num;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the normalized Gaussian kernel generator.
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic [11:0] sigma;
        logic [3:0]  size;
        logic        two_d;
        logic        drain;     // hold off until all taps are back
    } t_request;

    typedef struct {
        logic [16:0] coef;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
        logic        err;
    } t_tap;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [11:0] sigma, [15:12] kernel_size
    logic        s_axis_tuser = 1'b0; // [0] two_dimensional
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [16:0] coefficient, [19:17] row, [22:20] col
    logic        m_axis_tlast;
    logic        m_axis_tuser;        // [0] error

    t_request    pending_requests[$];
    t_tap        expected_taps[$];
    t_request    cur_req;
    int          mismatches = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    bit          req_taken = 1'b0;
    bit          feeding = 1'b0;

    gaussian_kernel_generator_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Q0.31 product, rounded to nearest, ties up.
    function automatic logic [63:0] q31_product(logic [63:0] a, logic [63:0] b);
        return (a * b + 64'h4000_0000) >> 31;
    endfunction

    // exp(-d2 / (2 sigma^2)) as saturated Q0.16.
    function automatic logic [15:0] tap_weight(int unsigned d2, logic [11:0] sg);
        logic [63:0] s2, x, t, p2, p3, p4, e, r;
        s2 = 64'(sg) * 64'(sg);
        x = ((64'(d2) << 31) + s2 / 2) / s2;
        if (x >= (64'd12 << 16)) return 16'd0;
        t = x << 5;
        p2 = q31_product(t, t);
        p3 = q31_product(p2, t);
        p4 = q31_product(p3, t);
        e = (64'd1 << 31) - t + (p2 >> 1) - p3 / 6 + p4 / 24;
        for (int i = 0; i < 10; i++) e = q31_product(e, e);
        r = (e + 64'h4000) >> 15;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    // Queue every normalized tap that a request produces.
    task automatic predict_kernel(t_request rq);
        logic [15:0] weights[64];
        logic [63:0] sum;
        int          n, centre, rows, dr, dc, k;
        t_tap        tp;
        n = rq.size;
        if (rq.sigma == 0 || n == 0) begin
            tp = '{coef: '0, row: '0, col: '0, last: 1'b1, err: 1'b1};
            expected_taps.push_back(tp);
            return;
        end
        if (n > 8) n = 8;
        centre = n / 2;
        rows = rq.two_d ? n : 1;
        sum = 0;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < n; c++) begin
                dc = c - centre;
                dr = rq.two_d ? r - centre : 0;
                weights[r * n + c] = tap_weight(dc * dc + dr * dr, rq.sigma);
                sum += weights[r * n + c];
            end
        end
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < n; c++) begin
                k = r * n + c;
                tp.coef = 17'(((64'(weights[k]) << 16) + sum / 2) / sum);
                tp.row = 3'(r);
                tp.col = 3'(c);
                tp.last = (k + 1 == rows * n);
                tp.err = 1'b0;
                expected_taps.push_back(tp);
            end
        end
    endtask

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        t_tap want;
        req_taken = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            req_taken = 1'b1;
            predict_kernel(cur_req);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_taps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected tap: data %h last %b err %b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want = expected_taps.pop_front();
                if (m_axis_tdata[16:0] !== want.coef || m_axis_tdata[19:17] !== want.row
                    || m_axis_tdata[22:20] !== want.col || m_axis_tdata[23] !== 1'b0
                    || m_axis_tlast !== want.last || m_axis_tuser !== want.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tap mismatch: want coef %0d row %0d col %0d last %b err %b, got coef %0d row %0d col %0d fill %b last %b err %b",
                                 want.coef, want.row, want.col, want.last, want.err,
                                 m_axis_tdata[16:0], m_axis_tdata[19:17],
                                 m_axis_tdata[22:20], m_axis_tdata[23],
                                 m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    // Request driver.
    always @(negedge i_clk) begin
        if (i_rst_n && feeding && (req_taken || !s_axis_tvalid)) begin
            if (req_taken) send_gap = pick_gap();
            if (send_gap > 0 || pending_requests.size() == 0
                || (pending_requests[0].drain && expected_taps.size() != 0)) begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end else begin
                cur_req = pending_requests.pop_front();
                s_axis_tdata <= {cur_req.size, cur_req.sigma};
                s_axis_tuser <= cur_req.two_d;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Coefficient channel back-pressure.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = pick_gap();
        end
    end

    task automatic add_request(int sg, int sz, int td, bit dr = 1'b0);
        t_request rq;
        rq.sigma = 12'(sg);
        rq.size = 4'(sz);
        rq.two_d = td[0];
        rq.drain = dr;
        pending_requests.push_back(rq);
    endtask

    initial begin
        int roll, sz;
        // Directed: errors, extremes, even/odd centres, saturated sizes.
        add_request(0, 5, 0);
        add_request(0, 8, 1);
        add_request(300, 0, 1);
        add_request(4095, 8, 1);
        add_request(4095, 15, 0);
        add_request(1, 8, 1);
        add_request(1, 1, 0);
        add_request(256, 1, 1);
        add_request(256, 2, 0);
        add_request(256, 4, 1);
        add_request(128, 5, 0);
        add_request(2048, 9, 0, 1'b1);
        add_request(64, 3, 1);
        add_request(3000, 7, 0);
        add_request(0, 0, 0);
        add_request(512, 12, 1);
        add_request(2730, 6, 0);
        add_request(100, 2, 1);
        for (int i = 0; i < 260; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                add_request($urandom_range(0, 1) ? 0 : $urandom_range(0, 4095),
                            $urandom_range(0, 1) ? 0 : $urandom_range(0, 15),
                            $urandom_range(0, 1));
                if (pending_requests[$].sigma != 0 && pending_requests[$].size != 0)
                    pending_requests[$].sigma = 12'd0;
            end else if (roll < 68) begin
                add_request($urandom_range(1, 4095), $urandom_range(1, 15), 0,
                            $urandom_range(0, 29) == 0);
            end else if (roll < 97) begin
                add_request($urandom_range(1, 4095), $urandom_range(1, 4), 1);
            end else begin
                sz = $urandom_range(5, 15);
                add_request($urandom_range(1, 4095), sz, 1);
            end
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        feeding = 1'b1;
        wait (pending_requests.size() == 0 && !s_axis_tvalid);
        wait (expected_taps.size() == 0);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && expected_taps.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
hdl/gkg_pkg.sv
hdl/gkg_ram.sv
hdl/gkg_div.sv
hdl/gaussian_kernel_generator_top.sv
tb/sv/testbench.sv
